[hdl/rdc_pkg.sv]
// Shared types and constants for the range distinct count block.
// No dependencies.
package rdc_pkg;

  localparam int MAX_ITEMS   = 1024;
  localparam int VALUE_COUNT = 4096;

  localparam int ACT_W = 2;
  localparam int VAL_W = 12;
  localparam int IDX_W = 10;
  localparam int LEN_W = 11;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALOOK,
    S_ACHK,
    S_WALK,
    S_DONE
  } state_e;

  // one stored element: its value and the earlier position of that value plus one
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [LEN_W-1:0] prev;
  } elem_t;

endpackage

[hdl/rdc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rdc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/range_distinct_count_core.sv]
// Top level of the range distinct count block: FSM, element store and last-seen table.
// Depends on rdc_pkg and rdc_ram.
//
// Items are taken one at a time. A clear resets the length when accepted; an append
// steps through last-seen lookup, element read, then check and write back, and is
// dropped when the store is full. A query walks the range, the element RAM read port
// delivering one stored position per cycle; a bad range skips the walk. A finished
// result is held in an output register, so clears and appends go on while it waits. The
// last-seen table is never swept: an entry counts as seen only if it points
// below the current length at an element holding the same value, so a clear
// is a length reset and no clearing pass follows reset.
module range_distinct_count_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [rdc_pkg::ACT_W-1:0] action_i,
  input  logic [rdc_pkg::VAL_W-1:0] value_i,
  input  logic [rdc_pkg::IDX_W-1:0] first_i,
  input  logic [rdc_pkg::IDX_W-1:0] last_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [rdc_pkg::LEN_W-1:0] distinct_count_o,
  output logic                     range_error_o
);

  localparam int ElemW = $bits(rdc_pkg::elem_t);

  rdc_pkg::state_e state_q, state_d;

  logic [rdc_pkg::LEN_W-1:0] len_q, len_d;
  logic [rdc_pkg::VAL_W-1:0] v_q, v_d;
  logic [rdc_pkg::IDX_W-1:0] p_q, p_d;
  logic [rdc_pkg::IDX_W-1:0] first_q, first_d;
  logic [rdc_pkg::IDX_W-1:0] last_q, last_d;
  logic [rdc_pkg::IDX_W-1:0] k_q, k_d;
  logic                      more_q, more_d;
  logic                      rd_vld_q, rd_vld_d;
  logic [rdc_pkg::LEN_W-1:0] rep_q, rep_d;
  logic                      err_q, err_d;
  logic                      ovld_q, ovld_d;
  logic [rdc_pkg::LEN_W-1:0] ocnt_q, ocnt_d;
  logic                      oerr_q, oerr_d;

  logic                      acc;
  logic                      bad;
  logic                      full;
  logic                      slot_free;
  logic [rdc_pkg::LEN_W-1:0] total;

  logic                      lp_we, lp_re;
  logic [rdc_pkg::VAL_W-1:0] lp_waddr, lp_raddr;
  logic [rdc_pkg::IDX_W-1:0] lp_wdata, lp_rdata;

  logic                      el_we, el_re;
  logic [rdc_pkg::IDX_W-1:0] el_waddr, el_raddr;
  rdc_pkg::elem_t            el_wdata, el_rd;
  logic [ElemW-1:0]          el_rdata;

  rdc_ram #(
    .DEPTH(rdc_pkg::VALUE_COUNT),
    .WIDTH(rdc_pkg::IDX_W)
  ) u_last_pos (
    .clk_i  (clk_i),
    .we_i   (lp_we),
    .waddr_i(lp_waddr),
    .wdata_i(lp_wdata),
    .re_i   (lp_re),
    .raddr_i(lp_raddr),
    .rdata_o(lp_rdata)
  );

  rdc_ram #(
    .DEPTH(rdc_pkg::MAX_ITEMS),
    .WIDTH(ElemW)
  ) u_elem (
    .clk_i  (clk_i),
    .we_i   (el_we),
    .waddr_i(el_waddr),
    .wdata_i(el_wdata),
    .re_i   (el_re),
    .raddr_i(el_raddr),
    .rdata_o(el_rdata)
  );

  assign el_rd      = rdc_pkg::elem_t'(el_rdata);
  assign in_ready_o = (state_q == rdc_pkg::S_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign full       = (len_q == rdc_pkg::LEN_W'(rdc_pkg::MAX_ITEMS));
  assign bad        = (first_i > last_i) || ({1'b0, last_i} >= len_q);
  assign slot_free  = !ovld_q || out_ready_i;
  assign total      = {1'b0, last_q} - {1'b0, first_q} + rdc_pkg::LEN_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rdc_pkg::S_IDLE: begin
        if (acc) begin
          case (action_i)
            rdc_pkg::ACT_APPEND: state_d = full ? rdc_pkg::S_IDLE : rdc_pkg::S_ALOOK;
            rdc_pkg::ACT_QUERY:  state_d = bad ? rdc_pkg::S_DONE : rdc_pkg::S_WALK;
            default:             state_d = rdc_pkg::S_IDLE;
          endcase
        end
      end
      rdc_pkg::S_ALOOK: state_d = rdc_pkg::S_ACHK;
      rdc_pkg::S_ACHK:  state_d = rdc_pkg::S_IDLE;
      rdc_pkg::S_WALK: begin
        if (!rd_vld_q && !more_q) state_d = rdc_pkg::S_DONE;
      end
      rdc_pkg::S_DONE: begin
        if (slot_free) state_d = rdc_pkg::S_IDLE;
      end
      default: state_d = rdc_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    len_d    = len_q;
    v_d      = v_q;
    p_d      = p_q;
    first_d  = first_q;
    last_d   = last_q;
    k_d      = k_q;
    more_d   = more_q;
    rd_vld_d = 1'b0;
    rep_d    = rep_q;
    err_d    = err_q;
    ovld_d   = ovld_q;
    ocnt_d   = ocnt_q;
    oerr_d   = oerr_q;

    lp_we    = 1'b0;
    lp_re    = 1'b0;
    lp_waddr = v_q;
    lp_raddr = value_i;
    lp_wdata = len_q[rdc_pkg::IDX_W-1:0];

    el_we    = 1'b0;
    el_re    = 1'b0;
    el_waddr = len_q[rdc_pkg::IDX_W-1:0];
    el_raddr = k_q;
    el_wdata.value = v_q;
    el_wdata.prev  = '0;

    if (ovld_q && out_ready_i) ovld_d = 1'b0;

    unique case (state_q)
      rdc_pkg::S_IDLE: begin
        if (acc) begin
          case (action_i)
            rdc_pkg::ACT_CLEAR: len_d = '0;
            rdc_pkg::ACT_APPEND: begin
              v_d   = value_i;
              lp_re = !full;
            end
            rdc_pkg::ACT_QUERY: begin
              first_d  = first_i;
              last_d   = last_i;
              err_d    = bad;
              rep_d    = '0;
              k_d      = first_i + rdc_pkg::IDX_W'(1);
              more_d   = (first_i != last_i);
              rd_vld_d = !bad;
              el_re    = !bad;
              el_raddr = first_i;
            end
            default: ;
          endcase
        end
      end
      rdc_pkg::S_ALOOK: begin
        p_d      = lp_rdata;
        el_re    = 1'b1;
        el_raddr = lp_rdata;
      end
      rdc_pkg::S_ACHK: begin
        // seen only if the entry points at a live element of the same value
        if (({1'b0, p_q} < len_q) && (el_rd.value == v_q)) begin
          el_wdata.prev = {1'b0, p_q} + rdc_pkg::LEN_W'(1);
        end else begin
          el_wdata.prev = '0;
        end
        el_we = 1'b1;
        lp_we = 1'b1;
        len_d = len_q + rdc_pkg::LEN_W'(1);
      end
      rdc_pkg::S_WALK: begin
        el_re    = more_q;
        rd_vld_d = more_q;
        if (more_q) begin
          k_d    = k_q + rdc_pkg::IDX_W'(1);
          more_d = (k_q != last_q);
        end
        if (rd_vld_q && (el_rd.prev > {1'b0, first_q})) begin
          rep_d = rep_q + rdc_pkg::LEN_W'(1);
        end
      end
      rdc_pkg::S_DONE: begin
        if (slot_free) begin
          ovld_d = 1'b1;
          oerr_d = err_q;
          ocnt_d = err_q ? '0 : total - rep_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rdc_pkg::S_IDLE;
      len_q    <= '0;
      more_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      more_q   <= more_d;
      rd_vld_q <= rd_vld_d;
      ovld_q   <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    p_q     <= p_d;
    first_q <= first_d;
    last_q  <= last_d;
    k_q     <= k_d;
    rep_q   <= rep_d;
    err_q   <= err_d;
    ocnt_q  <= ocnt_d;
    oerr_q  <= oerr_d;
  end

  assign out_valid_o      = ovld_q;
  assign distinct_count_o = ocnt_q;
  assign range_error_o    = oerr_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= rdc_pkg::LEN_W'(rdc_pkg::MAX_ITEMS))
    else $error("length beyond capacity");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(state_q == rdc_pkg::S_DONE))
    else $error("result loaded outside done state");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && oerr_q) |-> (ocnt_q == '0))
    else $error("error result with nonzero count");

  a_rep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rdc_pkg::S_WALK) |-> (rep_q <= total))
    else $error("repeat count exceeds range length");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rdc_pkg::S_WALK && more_q) |-> (k_q <= last_q))
    else $error("walk address past last index");

endmodule
